/* src/spl_pkg.sv */
// Shared types, constants and codes for the sorted priority list.
`default_nettype none

package spl_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KEY_BITS_DEF = 32;
    localparam int TAG_BITS_DEF = 16;

    localparam int KEY_W      = 32;
    localparam int TAG_W      = 16;
    localparam int HANDLE_W   = 16;
    localparam int OCC_W      = 5;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_DESC_ORDER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_MASK   = 1'b1;

    typedef enum logic [2:0] {
        CMD_INSERT   = 3'd0,
        CMD_POP      = 3'd1,
        CMD_PEEK     = 3'd2,
        CMD_FIND     = 3'd3,
        CMD_FIND_TAG = 3'd4,
        CMD_DEL      = 3'd5,
        CMD_DEL_TAG  = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_SHIFT,
        S_INS_PUT,
        S_SRCH_CMP,
        S_DEL_SHIFT,
        S_OUT
    } t_state;

    typedef struct packed {
        t_cmd                cmd;
        logic [KEY_W-1:0]    key;
        logic [TAG_W-1:0]    tag;
        logic [HANDLE_W-1:0] handle;
    } t_in;

    typedef struct packed {
        t_status             status;
        logic [KEY_W-1:0]    out_key;
        logic [TAG_W-1:0]    out_tag;
        logic [HANDLE_W-1:0] out_handle;
        logic [OCC_W-1:0]    occupancy;
    } t_out;

endpackage

`default_nettype wire

/* src/spl_store.sv */
// Entry memory: one write port, one read port with registered read data.
`default_nettype none

module spl_store #(
    parameter int DEPTH = spl_pkg::CAPACITY_DEF,
    parameter int WIDTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* src/sorted_priority_list.sv */
// Sorted priority list: top level with command sequencer and config registers.
//
// Usage: a command beat enters on i_valid/o_ready and one result beat leaves
// on o_valid/i_ready. One command is in flight at a time; o_ready is high
// only while the block is idle.
// Entries live in a memory, kept sorted by key (ascending, or descending when
// descending_order is set). A single comparator walks the memory, one entry
// per cycle, with the read data registered:
//   insert          : walks up from the first entry to the first one that
//                     ranks after the new key, writes the new entry there and
//                     carries each later entry up one slot.
//   pop/peek        : take the first entry; pop then shifts the tail down one slot.
//   find/delete     : walks up from the first entry until a match; delete then
//                     shifts the tail down one slot.
// Insert into a full list, commands on an empty list and unused codes go straight
// to the result, which is then held in an output register until taken;
// a stalled receiver simply holds the block in that state.
// Reset empties the list (count cleared, memory left as is), sets ascending
// order and an all-ones key match mask. Config writes take effect at once.
`default_nettype none

module sorted_priority_list #(
    parameter int CAPACITY = spl_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = spl_pkg::KEY_BITS_DEF,
    parameter int TAG_BITS = spl_pkg::TAG_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output      logic                            o_ready,
    input  wire spl_pkg::t_in                    i_data,
    output      logic                            o_valid,
    input  wire logic                            i_ready,
    output      spl_pkg::t_out                   o_data,
    input  wire logic                            i_cfg_we,
    input  wire logic [spl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [spl_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int KW = (KEY_BITS > spl_pkg::KEY_W) ? spl_pkg::KEY_W : KEY_BITS;
    localparam int TW = TAG_BITS;
    localparam int HW = spl_pkg::HANDLE_W;
    localparam int EW = KW + TW + HW;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = CW + 1;

    spl_pkg::t_state  r_state, n_state;
    spl_pkg::t_cmd    r_cmd, n_cmd;
    logic [KW-1:0]    r_key, n_key;
    logic [TW-1:0]    r_tag, n_tag;
    logic [HW-1:0]    r_handle, n_handle;
    logic [AW-1:0]    r_ptr, n_ptr;
    logic [CW-1:0]    r_count, n_count;
    spl_pkg::t_status r_status, n_status;
    logic [KW-1:0]    r_okey, n_okey;
    logic [TW-1:0]    r_otag, n_otag;
    logic [HW-1:0]    r_ohandle, n_ohandle;
    logic             r_desc;
    logic [spl_pkg::CFG_DATA_W-1:0] r_mask;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] rd_data;

    logic [KW-1:0] sk;
    logic [TW-1:0] st;
    logic [HW-1:0] sh;
    logic [EW-1:0] new_entry;
    logic          accept;
    logic          ranks_after;
    logic          hit;
    logic          is_first_cmd;
    logic          use_tag;
    logic          removes;
    logic          last;
    logic          last2;
    logic          full;
    logic          empty;

    spl_store #(
        .DEPTH (CAPACITY),
        .WIDTH (EW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign sk        = rd_data[EW-1 -: KW];
    assign st        = rd_data[HW +: TW];
    assign sh        = rd_data[HW-1:0];
    assign new_entry = {r_key, r_tag, r_handle};

    assign accept = i_valid && o_ready;
    assign full   = (r_count == CW'(CAPACITY));
    assign empty  = (r_count == '0);

    // shared comparator
    assign ranks_after  = r_desc ? (sk < r_key) : (sk > r_key);
    assign is_first_cmd = (r_cmd == spl_pkg::CMD_POP) || (r_cmd == spl_pkg::CMD_PEEK);
    assign use_tag      = (r_cmd == spl_pkg::CMD_FIND_TAG) || (r_cmd == spl_pkg::CMD_DEL_TAG);
    assign removes      = (r_cmd == spl_pkg::CMD_POP) || (r_cmd == spl_pkg::CMD_DEL)
                       || (r_cmd == spl_pkg::CMD_DEL_TAG);
    assign hit = is_first_cmd
              || ((((sk ^ r_key) & r_mask[KW-1:0]) == '0) && (!use_tag || (st == r_tag)));
    assign last  = (PW'(r_ptr) + PW'(1)) >= PW'(r_count);
    assign last2 = (PW'(r_ptr) + PW'(2)) >= PW'(r_count);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            spl_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (i_data.cmd)
                        spl_pkg::CMD_INSERT: begin
                            n_state = (full || empty) ? spl_pkg::S_OUT : spl_pkg::S_INS_CMP;
                        end
                        spl_pkg::CMD_POP, spl_pkg::CMD_PEEK, spl_pkg::CMD_FIND,
                        spl_pkg::CMD_FIND_TAG, spl_pkg::CMD_DEL,
                        spl_pkg::CMD_DEL_TAG: begin
                            n_state = empty ? spl_pkg::S_OUT : spl_pkg::S_SRCH_CMP;
                        end
                        default: begin
                            n_state = spl_pkg::S_OUT;
                        end
                    endcase
                end
            end
            spl_pkg::S_INS_CMP: begin
                if (last) begin
                    n_state = spl_pkg::S_INS_PUT;
                end else if (ranks_after) begin
                    n_state = spl_pkg::S_INS_SHIFT;
                end
            end
            spl_pkg::S_INS_SHIFT: begin
                if (last) begin
                    n_state = spl_pkg::S_INS_PUT;
                end
            end
            spl_pkg::S_INS_PUT: begin
                n_state = spl_pkg::S_OUT;
            end
            spl_pkg::S_SRCH_CMP: begin
                if (hit) begin
                    n_state = (removes && !last) ? spl_pkg::S_DEL_SHIFT : spl_pkg::S_OUT;
                end else if (last) begin
                    n_state = spl_pkg::S_OUT;
                end
            end
            spl_pkg::S_DEL_SHIFT: begin
                if (last2) begin
                    n_state = spl_pkg::S_OUT;
                end
            end
            spl_pkg::S_OUT: begin
                if (i_ready) begin
                    n_state = spl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = spl_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_cmd     = r_cmd;
        n_key     = r_key;
        n_tag     = r_tag;
        n_handle  = r_handle;
        n_ptr     = r_ptr;
        n_count   = r_count;
        n_status  = r_status;
        n_okey    = r_okey;
        n_otag    = r_otag;
        n_ohandle = r_ohandle;
        mem_we    = 1'b0;
        mem_waddr = r_ptr;
        mem_wdata = new_entry;
        rd_addr   = r_ptr;
        unique case (r_state)
            spl_pkg::S_IDLE: begin
                if (accept) begin
                    n_cmd     = i_data.cmd;
                    n_key     = i_data.key[KW-1:0];
                    n_tag     = i_data.tag[TW-1:0];
                    n_handle  = i_data.handle;
                    n_status  = spl_pkg::ST_MISS;
                    n_okey    = '0;
                    n_otag    = '0;
                    n_ohandle = '0;
                    n_ptr     = '0;
                    rd_addr   = '0;
                    if (i_data.cmd == spl_pkg::CMD_INSERT) begin
                        if (full) begin
                            n_status = spl_pkg::ST_FULL;
                        end else if (empty) begin
                            mem_we    = 1'b1;
                            mem_waddr = '0;
                            mem_wdata = {i_data.key[KW-1:0], i_data.tag[TW-1:0],
                                         i_data.handle};
                            n_count   = r_count + CW'(1);
                            n_status  = spl_pkg::ST_OK;
                        end
                    end
                end
            end
            spl_pkg::S_INS_CMP, spl_pkg::S_INS_SHIFT: begin
                n_ptr   = r_ptr + AW'(1);
                rd_addr = r_ptr + AW'(1);
                if ((r_state == spl_pkg::S_INS_SHIFT) || ranks_after) begin
                    // drop the carried entry here and carry the one it displaces
                    mem_we    = 1'b1;
                    mem_waddr = r_ptr;
                    mem_wdata = new_entry;
                    n_key     = sk;
                    n_tag     = st;
                    n_handle  = sh;
                end
            end
            spl_pkg::S_INS_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr;
                mem_wdata = new_entry;
                n_count   = r_count + CW'(1);
                n_status  = spl_pkg::ST_OK;
            end
            spl_pkg::S_SRCH_CMP: begin
                if (hit) begin
                    n_status  = spl_pkg::ST_OK;
                    n_okey    = sk;
                    n_otag    = st;
                    n_ohandle = sh;
                    if (removes) begin
                        if (last) begin
                            n_count = r_count - CW'(1);
                        end else begin
                            rd_addr = r_ptr + AW'(1);
                        end
                    end
                end else if (!last) begin
                    n_ptr   = r_ptr + AW'(1);
                    rd_addr = r_ptr + AW'(1);
                end
            end
            spl_pkg::S_DEL_SHIFT: begin
                // read data is the entry above r_ptr
                mem_we    = 1'b1;
                mem_waddr = r_ptr;
                mem_wdata = rd_data;
                if (last2) begin
                    n_count = r_count - CW'(1);
                end else begin
                    n_ptr   = r_ptr + AW'(1);
                    rd_addr = r_ptr + AW'(2);
                end
            end
            spl_pkg::S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spl_pkg::S_IDLE;
            r_count <= '0;
            r_desc  <= 1'b0;
            r_mask  <= '1;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    spl_pkg::CFG_DESC_ORDER: r_desc <= i_cfg_data[0];
                    spl_pkg::CFG_KEY_MASK:   r_mask <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_key     <= n_key;
        r_tag     <= n_tag;
        r_handle  <= n_handle;
        r_ptr     <= n_ptr;
        r_status  <= n_status;
        r_okey    <= n_okey;
        r_otag    <= n_otag;
        r_ohandle <= n_ohandle;
    end

    assign o_ready           = (r_state == spl_pkg::S_IDLE);
    assign o_valid           = (r_state == spl_pkg::S_OUT);
    assign o_data.status     = r_status;
    assign o_data.out_key    = spl_pkg::KEY_W'(r_okey);
    assign o_data.out_tag    = spl_pkg::TAG_W'(r_otag);
    assign o_data.out_handle = r_ohandle;
    assign o_data.occupancy  = spl_pkg::OCC_W'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_count_moves_at_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_count)) |-> (r_state == spl_pkg::S_OUT))
        else $error("entry count changed outside result posting");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_status == spl_pkg::ST_FULL)) |-> full)
        else $error("full status with free slots");

    a_miss_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_status != spl_pkg::ST_OK))
            |-> ((r_okey == '0) && (r_otag == '0) && (r_ohandle == '0)))
        else $error("entry fields nonzero on failed command");

endmodule

`default_nettype wire
